[src/assert_macros.svh]
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// whenever the condition holds, the consequence must hold in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("implication check failed");

// the condition must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

[src/hmtp_pkg.sv]
package hmtp_pkg;

  // byte classes produced by the front end
  localparam logic [3:0] CLS_SPACE   = 4'd0;
  localparam logic [3:0] CLS_NEWLINE = 4'd1;
  localparam logic [3:0] CLS_COMMA   = 4'd2;
  localparam logic [3:0] CLS_MINUS   = 4'd3;
  localparam logic [3:0] CLS_PLUS    = 4'd4;
  localparam logic [3:0] CLS_BLANK   = 4'd5;
  localparam logic [3:0] CLS_DEC     = 4'd6;
  localparam logic [3:0] CLS_HEX     = 4'd7;
  localparam logic [3:0] CLS_OTHER   = 4'd8;

  // token phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEIGHT = 2'd1;
  localparam logic [1:0] PH_PREFIX = 2'd2;
  localparam logic [1:0] PH_COLOR  = 2'd3;

  // height digit phases
  localparam logic [1:0] HD_LEAD   = 2'd0;
  localparam logic [1:0] HD_DIGITS = 2'd1;
  localparam logic [1:0] HD_STOP   = 2'd2;

  localparam logic [23:0] DEFAULT_COLOR_RESET = 24'hF31423;
  localparam logic [16:0] HEIGHT_ACC_MAX      = 17'h1FFFF;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // classified byte travelling through the queue
  typedef struct packed {
    logic [3:0] cls;
    logic [3:0] nib;
    logic       fin;
  } item_t;

endpackage

[src/height_map_text_parser.sv]
// height-map text parser
// s_* channel: one text byte per transaction, s_tdata[7:0] is the byte and
// s_tlast marks the final byte of the text (ends the open token and row).
// m_* channel: zero or one result per byte. m_tuser is point_valid, m_tlast
// is row_end; m_tdata carries column, row, height, colour, width error and
// the running lowest and highest heights.
// cfg_* channel: writes the 24-bit default colour, always ready; write it
// only while no byte is in flight.
// throughput: one byte per cycle sustained while the output is not stalled.
// The front end classifies each byte into a four-entry queue; the back end
// parses one queued byte per cycle into the output register unless stalled.
// Each accepted byte is first written into the queue and then parsed from
// the queue head into the output register.
// stall: while m_tready is low and a result is valid, the output register
// holds it, the back end stops and the queue fills; s_tready drops when it is full.
// reset: synchronous, clears the queue, the parser and the output valid flag
// and loads the default colour 0xF31423.
module height_map_text_parser
  import hmtp_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [9:0] column, [19:10] row, [35:20] height_value,
                                 // [59:36] color, [60] width_error, [76:61] lowest,
                                 // [92:77] highest, [95:93] zero
  output logic        m_tuser,   // [0] point_valid
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);

  item_t              front_item;
  item_t              head_item;
  logic               q_full;
  logic               q_not_empty;
  logic               q_pop;
  logic               push;
  logic [9:0]         column;
  logic [9:0]         row;
  logic signed [15:0] height_value;
  logic [23:0]        color;
  logic               width_error;
  logic signed [15:0] lowest;
  logic signed [15:0] highest;

  assign s_tready  = !q_full;
  assign push      = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // byte classification
  hmtp_front u_front (
    .char_byte  (s_tdata),
    .final_byte (s_tlast),
    .item       (front_item)
  );

  // decoupling queue
  hmtp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  // parser and output register
  hmtp_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_color   (cfg_data),
    .q_valid     (q_not_empty),
    .it          (head_item),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_point   (m_tuser),
    .out_column  (column),
    .out_row     (row),
    .out_height  (height_value),
    .out_color   (color),
    .out_row_end (m_tlast),
    .out_werr    (width_error),
    .out_lowest  (lowest),
    .out_highest (highest)
  );

  // result packing
  assign m_tdata = {3'b000, highest, lowest, width_error, color, height_value, row, column};

endmodule

[src/hmtp_front.sv]
module hmtp_front
  import hmtp_pkg::*;
(
  input  logic [7:0] char_byte,
  input  logic       final_byte,
  output item_t      item
);

  // classify the incoming byte and extract its digit value
  always_comb begin
    item.fin = final_byte;
    item.nib = 4'd0;
    item.cls = CLS_OTHER;
    if (char_byte == 8'h20) begin
      item.cls = CLS_SPACE;
    end else if (char_byte == 8'h0A) begin
      item.cls = CLS_NEWLINE;
    end else if (char_byte == 8'h2C) begin
      item.cls = CLS_COMMA;
    end else if (char_byte == 8'h2D) begin
      item.cls = CLS_MINUS;
    end else if (char_byte == 8'h2B) begin
      item.cls = CLS_PLUS;
    end else if (char_byte == 8'h09 || char_byte == 8'h0B ||
                 char_byte == 8'h0C || char_byte == 8'h0D) begin
      item.cls = CLS_BLANK;
    end else if (char_byte >= 8'h30 && char_byte <= 8'h39) begin
      item.cls = CLS_DEC;
      item.nib = 4'(char_byte - 8'h30);
    end else if (char_byte >= 8'h61 && char_byte <= 8'h66) begin
      item.cls = CLS_HEX;
      item.nib = 4'(char_byte - 8'h57);
    end else if (char_byte >= 8'h41 && char_byte <= 8'h46) begin
      item.cls = CLS_HEX;
      item.nib = 4'(char_byte - 8'h37);
    end
  end

endmodule

[src/hmtp_queue.sv]
`include "assert_macros.svh"

module hmtp_queue
  import hmtp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  item_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst, push && full && !pop)
  `ASSERT_NEVER(a_no_underflow, clk, rst, pop && !not_empty)

endmodule

[src/hmtp_back.sv]
`include "assert_macros.svh"

module hmtp_back
  import hmtp_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [23:0]  cfg_color,
  input  logic         q_valid,
  input  item_t        it,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         out_point,
  output logic [9:0]   out_column,
  output logic [9:0]   out_row,
  output logic signed [15:0] out_height,
  output logic [23:0]  out_color,
  output logic         out_row_end,
  output logic         out_werr,
  output logic signed [15:0] out_lowest,
  output logic signed [15:0] out_highest
);

  localparam int CW = $clog2(MAX_COLUMNS + 2);
  localparam int RW = $clog2(MAX_ROWS + 1);

  // parser state
  logic [23:0]        default_color;
  logic [1:0]         phase, phase_next;
  logic               neg, neg_next;
  logic [16:0]        hacc, hacc_next;
  logic [23:0]        cacc, cacc_next;
  logic               pskip, pskip_next;
  logic [1:0]         dph, dph_next;
  logic               cstop, cstop_next;
  logic [CW-1:0]      ccount, ccount_next;
  logic [RW-1:0]      rcount, rcount_next;
  logic [CW-1:0]      expw, expw_next;
  logic               first_pend, first_pend_next;
  logic signed [15:0] min_h, min_h_next;
  logic signed [15:0] max_h, max_h_next;

  // result of the current byte
  logic               res_point;
  logic               res_end;
  logic               res_err;
  logic [9:0]         res_col;
  logic [9:0]         res_row;
  logic signed [15:0] res_height;
  logic [23:0]        res_color;
  logic signed [15:0] res_low;
  logic signed [15:0] res_high;

  assign q_pop = q_valid && (!out_valid || out_ready);

  // next state and result for one classified byte
  always_comb begin
    logic               is_space;
    logic               is_nl;
    logic               fed;
    logic               take;
    logic               finish;
    logic [20:0]        prod;
    logic [16:0]        hneg;
    logic signed [15:0] h;
    logic [31:0]        col_wide;
    logic [31:0]        row_wide;
    logic [RW-1:0]      row_sel;

    phase_next      = phase;
    neg_next        = neg;
    hacc_next       = hacc;
    cacc_next       = cacc;
    pskip_next      = pskip;
    dph_next        = dph;
    cstop_next      = cstop;
    ccount_next     = ccount;
    rcount_next     = rcount;
    expw_next       = expw;
    first_pend_next = first_pend;
    min_h_next      = min_h;
    max_h_next      = max_h;
    res_point       = 1'b0;
    res_end         = 1'b0;
    res_err         = 1'b0;
    res_col         = '0;
    res_row         = '0;
    res_height      = '0;
    res_color       = '0;
    take            = 1'b0;
    prod            = '0;
    hneg            = '0;
    h               = '0;
    col_wide        = '0;

    is_space = (it.cls == CLS_SPACE);
    is_nl    = (it.cls == CLS_NEWLINE);
    fed      = !is_space && !is_nl;

    // row index reported with points and row ends
    row_sel  = (rcount < RW'(MAX_ROWS)) ? rcount : RW'(MAX_ROWS - 1);
    row_wide = 32'(row_sel);

    // token byte handling
    if (fed) begin
      if (phase_next == PH_IDLE) begin
        phase_next = PH_HEIGHT;
        neg_next   = 1'b0;
        hacc_next  = '0;
        cacc_next  = '0;
        pskip_next = 1'b0;
        dph_next   = HD_LEAD;
        cstop_next = 1'b0;
      end
      case (phase_next)
        PH_HEIGHT: begin
          if (it.cls == CLS_COMMA) begin
            phase_next = PH_PREFIX;
            pskip_next = 1'b0;
            cacc_next  = '0;
            cstop_next = 1'b0;
          end else begin
            take = 1'b1;
            if (dph_next == HD_LEAD) begin
              if (it.cls == CLS_BLANK) begin
                take = 1'b0;
              end else begin
                dph_next = HD_DIGITS;
                if (it.cls == CLS_MINUS) begin
                  neg_next = 1'b1;
                  take     = 1'b0;
                end else if (it.cls == CLS_PLUS) begin
                  take = 1'b0;
                end
              end
            end
            if (take && dph_next == HD_DIGITS) begin
              if (it.cls == CLS_DEC) begin
                prod = (21'(hacc_next) << 3) + (21'(hacc_next) << 1) + 21'(it.nib);
                hacc_next = (prod > 21'(HEIGHT_ACC_MAX)) ? HEIGHT_ACC_MAX : prod[16:0];
              end else begin
                dph_next = HD_STOP;
              end
            end
          end
        end
        PH_PREFIX: begin
          if (pskip_next) begin
            phase_next = PH_COLOR;
          end
          pskip_next = 1'b1;
        end
        PH_COLOR: begin
          if (!cstop_next) begin
            if (it.cls == CLS_DEC || it.cls == CLS_HEX) begin
              cacc_next = {cacc_next[19:0], it.nib};
            end else begin
              cstop_next = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    // token end
    finish = ((is_space || is_nl) && phase != PH_IDLE) || (fed && it.fin);
    if (finish) begin
      hneg = ~hacc_next + 17'd1;
      if (neg_next) begin
        h = (hacc_next > 17'd32768) ? 16'sh8000 : $signed(hneg[15:0]);
      end else begin
        h = (hacc_next > 17'd32767) ? 16'sh7FFF : $signed(hacc_next[15:0]);
      end
      if (ccount < CW'(MAX_COLUMNS) && rcount < RW'(MAX_ROWS)) begin
        col_wide   = 32'(ccount);
        res_point  = 1'b1;
        res_col    = col_wide[9:0];
        res_row    = row_wide[9:0];
        res_height = h;
        res_color  = (phase_next == PH_HEIGHT) ? default_color : cacc_next;
        if (h < min_h_next) begin
          min_h_next = h;
        end
        if (h > max_h_next) begin
          max_h_next = h;
        end
      end
      if (ccount <= CW'(MAX_COLUMNS)) begin
        ccount_next = ccount + 1'b1;
      end
      phase_next = PH_IDLE;
    end

    // row end
    if (is_nl || it.fin) begin
      res_end = 1'b1;
      res_row = row_wide[9:0];
      if (first_pend) begin
        expw_next       = ccount_next;
        first_pend_next = 1'b0;
      end else if (ccount_next != expw) begin
        res_err = 1'b1;
      end
      if (rcount < RW'(MAX_ROWS)) begin
        rcount_next = rcount + 1'b1;
      end
      ccount_next = '0;
    end

    res_low  = min_h_next;
    res_high = max_h_next;

    // last byte of the text returns the parser to its start state
    if (it.fin) begin
      phase_next      = PH_IDLE;
      neg_next        = 1'b0;
      hacc_next       = '0;
      cacc_next       = '0;
      pskip_next      = 1'b0;
      dph_next        = HD_LEAD;
      cstop_next      = 1'b0;
      ccount_next     = '0;
      rcount_next     = '0;
      expw_next       = '0;
      first_pend_next = 1'b1;
      min_h_next      = '0;
      max_h_next      = '0;
    end
  end

  // default colour register
  always_ff @(posedge clk) begin
    if (rst) begin
      default_color <= DEFAULT_COLOR_RESET;
    end else if (cfg_write) begin
      default_color <= cfg_color;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      neg        <= 1'b0;
      hacc       <= '0;
      cacc       <= '0;
      pskip      <= 1'b0;
      dph        <= HD_LEAD;
      cstop      <= 1'b0;
      ccount     <= '0;
      rcount     <= '0;
      expw       <= '0;
      first_pend <= 1'b1;
      min_h      <= '0;
      max_h      <= '0;
    end else if (q_pop) begin
      phase      <= phase_next;
      neg        <= neg_next;
      hacc       <= hacc_next;
      cacc       <= cacc_next;
      pskip      <= pskip_next;
      dph        <= dph_next;
      cstop      <= cstop_next;
      ccount     <= ccount_next;
      rcount     <= rcount_next;
      expw       <= expw_next;
      first_pend <= first_pend_next;
      min_h      <= min_h_next;
      max_h      <= max_h_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && (res_point || res_end)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (q_pop && (res_point || res_end)) begin
      out_point   <= res_point;
      out_column  <= res_col;
      out_row     <= res_row;
      out_height  <= res_height;
      out_color   <= res_color;
      out_row_end <= res_end;
      out_werr    <= res_err;
      out_lowest  <= res_low;
      out_highest <= res_high;
    end
  end

  `ASSERT_IMPLIES(a_point_in_range, clk, rst, out_valid && out_point,
                  (out_lowest <= out_height) && (out_height <= out_highest))
  `ASSERT_IMPLIES(a_err_needs_row_end, clk, rst, out_valid && out_werr, out_row_end)
  `ASSERT_NEVER(a_empty_result, clk, rst, out_valid && !out_point && !out_row_end)

endmodule
